[design/bsfm_pkg.sv]
package bsfm_pkg;

  // Field widths
  localparam int CODE_W  = 10;
  localparam int GAIN_W  = 18;
  localparam int VAL_W   = 16;
  localparam int SOC_W   = 8;
  localparam int FAULT_W = 2;
  localparam int CFG_W   = 18;
  localparam int IDX_W   = 2;
  localparam int PROD_W  = CODE_W + GAIN_W;
  localparam int GAIN_FRAC = 12;

  // Stream payload widths, rounded up to whole bytes
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_VOLT_GAIN      = 2'd0;
  localparam logic [IDX_W-1:0] REG_TEMP_GAIN      = 2'd1;
  localparam logic [IDX_W-1:0] REG_OVERVOLT_LIMIT = 2'd2;
  localparam logic [IDX_W-1:0] REG_OVERTEMP_LIMIT = 2'd3;

  // Register reset values
  localparam logic [GAIN_W-1:0] VOLT_GAIN_RST      = 18'd60000;
  localparam logic [GAIN_W-1:0] TEMP_GAIN_RST      = 18'd20000;
  localparam logic [VAL_W-1:0]  OVERVOLT_LIMIT_RST = 16'd12800;
  localparam logic [VAL_W-1:0]  OVERTEMP_LIMIT_RST = 16'd450;

  // Temperature ring entries come out of reset at 25.0 C
  localparam logic [VAL_W-1:0] TEMP_RST = 16'd250;

  // Fault codes
  localparam logic [FAULT_W-1:0] FAULT_NONE     = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_OVERVOLT = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_OVERTEMP = 2'd2;

  // 3S Li-ion charge table, highest band first
  localparam int SOC_STEPS = 15;
  localparam logic [VAL_W-1:0] SOC_THRESH_MV [SOC_STEPS] = '{
    16'd12600, 16'd12450, 16'd12300, 16'd12150, 16'd12000,
    16'd11850, 16'd11700, 16'd11550, 16'd11400, 16'd11250,
    16'd11100, 16'd10950, 16'd10800, 16'd10500, 16'd9000
  };
  localparam logic [SOC_W-1:0] SOC_VALUE [SOC_STEPS] = '{
    8'd200, 8'd190, 8'd180, 8'd165, 8'd150,
    8'd135, 8'd120, 8'd105, 8'd90,  8'd75,
    8'd60,  8'd45,  8'd30,  8'd20,  8'd10
  };
  localparam logic [SOC_W-1:0] SOC_EMPTY = 8'd0;

  // First band whose threshold the voltage reaches; parallel compares
  function automatic logic [SOC_W-1:0] soc_lookup(input logic [VAL_W-1:0] mv);
    logic [SOC_W-1:0] soc;
    soc = SOC_EMPTY;
    for (int i = SOC_STEPS - 1; i >= 0; i--) begin
      if (mv >= SOC_THRESH_MV[i]) begin
        soc = SOC_VALUE[i];
      end
    end
    return soc;
  endfunction

endpackage

[design/battery_soc_and_fault_monitor.sv]
// Battery monitor: each input beat carries a raw voltage and a raw temperature
// ADC code; each output beat carries pack millivolts, the mean of the last
// AVG_DEPTH temperatures in tenths of a degree (current sample included),
// state of charge in half percent and a fault code (overvoltage before
// overtemperature). One beat is taken every clock while the output side keeps
// up; a result passes through the input register, gain multipliers,
// temperature ring with running sum and result register. The temperature
// mean comes from a running total of the ring, so the ring costs one add and
// one subtract per beat whatever its depth. Registers must be written through
// cfg_we/cfg_index/cfg_data only while no beats are in flight; the block
// itself does not enforce this.
module battery_soc_and_fault_monitor
  import bsfm_pkg::*;
#(
  parameter int AVG_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // volt_code[9:0], temp_code[19:10]
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // pack_mv[15:0], temp_avg_decideg[31:16],
                                                // soc_half_pct[39:32], fault_code[41:40]
  // Register writes
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int SUM_W = VAL_W + $clog2(AVG_DEPTH);

  // Configuration registers
  logic [GAIN_W-1:0] volt_gain;
  logic [GAIN_W-1:0] temp_gain;
  logic [VAL_W-1:0]  overvolt_limit_mv;
  logic [VAL_W-1:0]  overtemp_limit_decideg;

  always_ff @(posedge clk) begin
    if (rst) begin
      volt_gain              <= VOLT_GAIN_RST;
      temp_gain              <= TEMP_GAIN_RST;
      overvolt_limit_mv      <= OVERVOLT_LIMIT_RST;
      overtemp_limit_decideg <= OVERTEMP_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VOLT_GAIN:      volt_gain              <= cfg_data;
        REG_TEMP_GAIN:      temp_gain              <= cfg_data;
        REG_OVERVOLT_LIMIT: overvolt_limit_mv      <= cfg_data[VAL_W-1:0];
        REG_OVERTEMP_LIMIT: overtemp_limit_decideg <= cfg_data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or moving on
  logic v_in, v_scl, v_ring, v_out;
  logic rdy_in, rdy_scl, rdy_ring, rdy_out;

  assign rdy_out  = !v_out  || m_axis_tready;
  assign rdy_ring = !v_ring || rdy_out;
  assign rdy_scl  = !v_scl  || rdy_ring;
  assign rdy_in   = !v_in   || rdy_scl;

  assign s_axis_tready = rdy_in;
  assign m_axis_tvalid = v_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in   <= 1'b0;
      v_scl  <= 1'b0;
      v_ring <= 1'b0;
      v_out  <= 1'b0;
    end else begin
      if (rdy_in)   v_in   <= s_axis_tvalid;
      if (rdy_scl)  v_scl  <= v_in;
      if (rdy_ring) v_ring <= v_scl;
      if (rdy_out)  v_out  <= v_ring;
    end
  end

  // Input register
  logic [CODE_W-1:0] volt_code;
  logic [CODE_W-1:0] temp_code;

  always_ff @(posedge clk) begin
    if (rdy_in) begin
      volt_code <= s_axis_tdata[CODE_W-1:0];
      temp_code <= s_axis_tdata[2*CODE_W-1:CODE_W];
    end
  end

  // Gain scaling
  logic [VAL_W-1:0] scl_mv;
  logic [VAL_W-1:0] scl_temp;

  bsfm_scale u_scale (
    .clk          (clk),
    .en           (rdy_scl),
    .volt_code    (volt_code),
    .temp_code    (temp_code),
    .volt_gain    (volt_gain),
    .temp_gain    (temp_gain),
    .pack_mv      (scl_mv),
    .temp_decideg (scl_temp)
  );

  // Ring stage: temperature history plus voltage-side lookups
  logic [SUM_W-1:0] ring_sum;
  logic [VAL_W-1:0] ring_mv;
  logic [SOC_W-1:0] ring_soc;
  logic             ring_ov;

  bsfm_temp_ring #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_ring (
    .clk          (clk),
    .rst          (rst),
    .push         (rdy_ring && v_scl),
    .temp_decideg (scl_temp),
    .sum          (ring_sum)
  );

  always_ff @(posedge clk) begin
    if (rdy_ring) begin
      ring_mv  <= scl_mv;
      ring_soc <= soc_lookup(scl_mv);
      ring_ov  <= (scl_mv >= overvolt_limit_mv);
    end
  end

  // Mean, fault priority and result register
  logic [VAL_W-1:0]   out_mv;
  logic [VAL_W-1:0]   out_temp;
  logic [SOC_W-1:0]   out_soc;
  logic [FAULT_W-1:0] out_fault;

  bsfm_result #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_result (
    .clk              (clk),
    .en               (rdy_out),
    .sum              (ring_sum),
    .pack_mv_in       (ring_mv),
    .soc_in           (ring_soc),
    .overvolt         (ring_ov),
    .overtemp_limit   (overtemp_limit_decideg),
    .pack_mv          (out_mv),
    .temp_avg_decideg (out_temp),
    .soc_half_pct     (out_soc),
    .fault_code       (out_fault)
  );

  assign m_axis_tdata = {
    (OUT_DATA_W - 2*VAL_W - SOC_W - FAULT_W)'(0),
    out_fault, out_soc, out_temp, out_mv
  };

endmodule

[design/bsfm_scale.sv]
module bsfm_scale
  import bsfm_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [CODE_W-1:0] volt_code,
  input  logic [CODE_W-1:0] temp_code,
  input  logic [GAIN_W-1:0] volt_gain,
  input  logic [GAIN_W-1:0] temp_gain,
  output logic [VAL_W-1:0]  pack_mv,
  output logic [VAL_W-1:0]  temp_decideg
);

  logic [PROD_W-1:0] volt_prod;
  logic [PROD_W-1:0] temp_prod;

  // 10 x 18 bit products in Q.12; after dropping the fraction the largest
  // possible value is still below 2^16, so the 16-bit slice never overflows
  assign volt_prod = PROD_W'(volt_code) * PROD_W'(volt_gain);
  assign temp_prod = PROD_W'(temp_code) * PROD_W'(temp_gain);

  always_ff @(posedge clk) begin
    if (en) begin
      pack_mv      <= volt_prod[GAIN_FRAC +: VAL_W];
      temp_decideg <= temp_prod[GAIN_FRAC +: VAL_W];
    end
  end

endmodule

[design/bsfm_temp_ring.sv]
module bsfm_temp_ring
  import bsfm_pkg::*;
#(
  parameter int AVG_DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  input  logic [VAL_W-1:0]                       temp_decideg,
  output logic [VAL_W+$clog2(AVG_DEPTH)-1:0]     sum
);

  localparam int PTR_W = $clog2(AVG_DEPTH);
  localparam int SUM_W = VAL_W + PTR_W;
  localparam logic [SUM_W-1:0] SUM_RST = SUM_W'(int'(TEMP_RST) * AVG_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(AVG_DEPTH - 1);

  logic [VAL_W-1:0] ring [AVG_DEPTH];
  logic [PTR_W-1:0] ring_pointer;
  logic [SUM_W-1:0] sum_next;

  // Running total: add the new sample, drop the one it replaces
  assign sum_next = sum + SUM_W'(temp_decideg) - SUM_W'(ring[ring_pointer]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring[i] <= TEMP_RST;
      end
      ring_pointer <= '0;
      sum          <= SUM_RST;
    end else if (push) begin
      ring[ring_pointer] <= temp_decideg;
      ring_pointer       <= (ring_pointer == PTR_LAST) ? '0 : ring_pointer + 1'b1;
      sum                <= sum_next;
    end
  end

endmodule

[design/bsfm_result.sv]
module bsfm_result
  import bsfm_pkg::*;
#(
  parameter int AVG_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [VAL_W+$clog2(AVG_DEPTH)-1:0] sum,
  input  logic [VAL_W-1:0]                   pack_mv_in,
  input  logic [SOC_W-1:0]                   soc_in,
  input  logic                               overvolt,
  input  logic [VAL_W-1:0]                   overtemp_limit,
  output logic [VAL_W-1:0]                   pack_mv,
  output logic [VAL_W-1:0]                   temp_avg_decideg,
  output logic [SOC_W-1:0]                   soc_half_pct,
  output logic [FAULT_W-1:0]                 fault_code
);

  localparam int LOG_D     = $clog2(AVG_DEPTH);
  localparam int SUM_W     = VAL_W + LOG_D;
  localparam int DIV_SHIFT = SUM_W + LOG_D;
  localparam int MUL_W     = 2 * SUM_W + 1;
  // Rounded-up reciprocal; exact floor for every sum of SUM_W bits
  localparam logic [SUM_W:0] DIV_MULT =
    (SUM_W+1)'(((64'd1 << DIV_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

  logic [MUL_W-1:0]   div_prod;
  logic [VAL_W-1:0]   avg;
  logic [FAULT_W-1:0] fault;

  // Mean of the ring by reciprocal multiply
  assign div_prod = MUL_W'(sum) * MUL_W'(DIV_MULT);
  assign avg      = div_prod[DIV_SHIFT +: VAL_W];

  // Overvoltage wins over overtemperature
  always_comb begin
    if (overvolt) begin
      fault = FAULT_OVERVOLT;
    end else if (avg >= overtemp_limit) begin
      fault = FAULT_OVERTEMP;
    end else begin
      fault = FAULT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pack_mv          <= pack_mv_in;
      temp_avg_decideg <= avg;
      soc_half_pct     <= soc_in;
      fault_code       <= fault;
    end
  end

endmodule

[design/bsfm_checker.sv]
module bsfm_checker
  import bsfm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [VAL_W-1:0]   mv;
  logic [SOC_W-1:0]   soc;
  logic [FAULT_W-1:0] fault;

  assign mv    = m_axis_tdata[VAL_W-1:0];
  assign soc   = m_axis_tdata[2*VAL_W +: SOC_W];
  assign fault = m_axis_tdata[2*VAL_W+SOC_W +: FAULT_W];

  // A stalled result beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat shown right after reset");

  // Fault code is one of the three defined codes
  a_fault_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (fault == FAULT_NONE || fault == FAULT_OVERVOLT ||
                       fault == FAULT_OVERTEMP))
    else $error("undefined fault code");

  // Charge figure follows the voltage of the same beat at the table ends
  a_soc_ends: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((mv >= SOC_THRESH_MV[0]) == (soc == SOC_VALUE[0])) &&
                      ((mv < SOC_THRESH_MV[SOC_STEPS-1]) == (soc == SOC_EMPTY)))
    else $error("state of charge does not match pack voltage");

endmodule

bind battery_soc_and_fault_monitor bsfm_checker u_bsfm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
